// File: hw/rtl/akdr_pkg.sv
// Shared constants, types and the threshold table of the ladder keypad block.
`timescale 1ns / 1ps
`default_nettype none

package akdr_pkg;

    // Width of the raw converter sample on the input port.
    localparam int ADC_BITS = 12;

    // The ladder compares are made on a 12-bit value.
    localparam int LADDER_BITS = 12;
    localparam int NUM_KEYS    = 8;
    localparam int KEY_W       = 4;
    localparam int REG_W       = 8;
    localparam int CNT_W       = 9;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [KEY_W-1:0] NO_KEY    = '0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MASK   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] LONG_PRESS_RESET = 8'd80;
    localparam logic [REG_W-1:0] REPEAT_RESET     = 8'd10;
    localparam logic [REG_W-1:0] KEY_MASK_RESET   = 8'd6;

    // Upper bound (exclusive) of each key's voltage band, key 1 first.
    localparam logic [LADDER_BITS-1:0] LADDER_TOP [NUM_KEYS] = '{
        12'd150, 12'd800, 12'd1600, 12'd2000,
        12'd2700, 12'd3300, 12'd3700, 12'd4000
    };

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_HELD    = 2'd2,
        PH_REPEAT  = 2'd3
    } phase_t;

endpackage : akdr_pkg

`default_nettype wire

// File: hw/rtl/adc_ladder_key_debounce_repeat_unit.sv
// Top level of the resistor ladder keypad: debounce, long press and auto-repeat.
`timescale 1ns / 1ps
`default_nettype none

// One converter sample is taken as an item on every tick and gives exactly one
// event item back, whose key_event is the key code fired on that tick or 0 when
// nothing fired. A key must be seen on two successive samples before it counts.
// A release before the long-press time fires the key once; a key held past it
// fires once if its bit in key_mask_reg is clear, or fires and then repeats
// once per repeat_reg + 1 samples while it stays down if the bit is set. A release
// at exactly the long-press count fires nothing. The block takes one item in
// every cycle unless sample_stall is high: the sample is registered, the ladder
// compare and state update are combinational, and the event sits in an output
// register. The sample register also acts as a spare slot, so one more item is
// taken while an event waits to be drained. The three configuration registers
// are written at indexes 0, 1 and 2; a write to index 3 is ignored. cfg_ready
// is always high, and writes belong to times when no item is in flight.

module adc_ladder_key_debounce_repeat_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic [akdr_pkg::ADC_BITS-1:0]      adc_sample,

    output logic                                    event_valid,
    input  wire logic                               event_stall,
    output logic      [akdr_pkg::KEY_W-1:0]         key_event,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [akdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [akdr_pkg::REG_W-1:0]         cfg_data
);

    // Configuration registers.
    logic [akdr_pkg::REG_W-1:0] long_press_reg;
    logic [akdr_pkg::REG_W-1:0] repeat_reg;
    logic [akdr_pkg::REG_W-1:0] key_mask_reg;

    // Input stage.
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [akdr_pkg::ADC_BITS-1:0] sample_reg;

    // Key tracking state.
    akdr_pkg::phase_t           phase_reg;
    akdr_pkg::phase_t           phase_next;
    logic [akdr_pkg::CNT_W-1:0] hold_count_reg;
    logic [akdr_pkg::CNT_W-1:0] hold_count_next;
    logic [akdr_pkg::KEY_W-1:0] held_key_reg;
    logic [akdr_pkg::KEY_W-1:0] held_key_next;

    // Output stage.
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [akdr_pkg::KEY_W-1:0] key_event_reg;
    logic [akdr_pkg::KEY_W-1:0] event_next;

    logic                       accept;
    logic                       advance;
    logic [akdr_pkg::KEY_W-1:0] key;
    logic [akdr_pkg::CNT_W-1:0] count_up;
    logic [akdr_pkg::CNT_W-1:0] long_press_ext;
    logic [akdr_pkg::CNT_W-1:0] repeat_ext;
    logic                       held_repeats;

    // The sample stage moves on whenever the output register is free or drains
    // in the same cycle; the input side only waits when both slots are taken.
    assign advance       = s1_valid_reg && (!out_valid_reg || !event_stall);
    assign sample_stall  = s1_valid_reg && !advance;
    assign accept        = sample_valid && !sample_stall;
    assign s1_valid_next = accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && event_stall);

    assign event_valid = out_valid_reg;
    assign key_event   = key_event_reg;
    assign cfg_ready   = 1'b1;

    akdr_ladder u_ladder
    (
        .sample (sample_reg),
        .key    (key)
    );

    assign count_up       = (hold_count_reg == akdr_pkg::COUNT_MAX) ? hold_count_reg
                                                                    : hold_count_reg + 1'b1;
    assign long_press_ext = {1'b0, long_press_reg};
    assign repeat_ext     = {1'b0, repeat_reg};

    // A held key repeats only if it is a real key and its mask bit is set.
    always_comb
    begin
        held_repeats = 1'b0;
        if ((held_key_reg != akdr_pkg::NO_KEY) &&
            (held_key_reg <= akdr_pkg::KEY_W'(akdr_pkg::NUM_KEYS)))
        begin
            held_repeats = key_mask_reg[3'(held_key_reg - 1'b1)];
        end
    end

    // Next state and event of the key tracker for the sample in the input stage.
    always_comb
    begin
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        held_key_next   = held_key_reg;
        event_next      = akdr_pkg::NO_KEY;

        case (phase_reg)
            akdr_pkg::PH_IDLE:
            begin
                if (key != akdr_pkg::NO_KEY)
                begin
                    phase_next = akdr_pkg::PH_CONFIRM;
                end
            end
            akdr_pkg::PH_CONFIRM:
            begin
                if (key != akdr_pkg::NO_KEY)
                begin
                    phase_next    = akdr_pkg::PH_HELD;
                    held_key_next = key;
                end
                else
                begin
                    phase_next = akdr_pkg::PH_IDLE;
                end
            end
            akdr_pkg::PH_HELD:
            begin
                hold_count_next = count_up;
                if ((count_up < long_press_ext) && (key == akdr_pkg::NO_KEY))
                begin
                    // Short press released.
                    event_next      = held_key_reg;
                    hold_count_next = '0;
                    phase_next      = akdr_pkg::PH_IDLE;
                    held_key_next   = akdr_pkg::NO_KEY;
                end
                else if ((count_up > long_press_ext) && !held_repeats)
                begin
                    // Long press of a key without repeat fires once and forgets the key.
                    event_next      = held_key_reg;
                    hold_count_next = '0;
                    held_key_next   = akdr_pkg::NO_KEY;
                end
                else if ((key != akdr_pkg::NO_KEY) && (count_up > long_press_ext))
                begin
                    phase_next      = akdr_pkg::PH_REPEAT;
                    event_next      = held_key_reg;
                    hold_count_next = '0;
                end
                else if (key == akdr_pkg::NO_KEY)
                begin
                    // Release on the long-press boundary fires nothing.
                    phase_next      = akdr_pkg::PH_IDLE;
                    held_key_next   = akdr_pkg::NO_KEY;
                    hold_count_next = '0;
                end
            end
            akdr_pkg::PH_REPEAT:
            begin
                hold_count_next = count_up;
                if ((key != akdr_pkg::NO_KEY) && (count_up > repeat_ext))
                begin
                    hold_count_next = '0;
                    event_next      = held_key_reg;
                end
                else if (key == akdr_pkg::NO_KEY)
                begin
                    hold_count_next = '0;
                    phase_next      = akdr_pkg::PH_IDLE;
                    held_key_next   = akdr_pkg::NO_KEY;
                end
            end
            default:
            begin
                phase_next = akdr_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= akdr_pkg::LONG_PRESS_RESET;
            repeat_reg     <= akdr_pkg::REPEAT_RESET;
            key_mask_reg   <= akdr_pkg::KEY_MASK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                akdr_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                akdr_pkg::CFG_REPEAT:     repeat_reg     <= cfg_data;
                akdr_pkg::CFG_KEY_MASK:   key_mask_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= akdr_pkg::PH_IDLE;
            hold_count_reg <= '0;
            held_key_reg   <= akdr_pkg::NO_KEY;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg      <= phase_next;
                hold_count_reg <= hold_count_next;
                held_key_reg   <= held_key_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= adc_sample;
        end
        if (advance)
        begin
            key_event_reg <= event_next;
        end
    end

`ifndef SYNTHESIS
    // No key is latched until the key has been confirmed.
    a_no_key_before_held: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == akdr_pkg::PH_IDLE || phase_reg == akdr_pkg::PH_CONFIRM)
        |-> (held_key_reg == akdr_pkg::NO_KEY))
        else $error("held key set while idle or confirming");

    // Repeat is only entered with a real key latched.
    a_repeat_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == akdr_pkg::PH_REPEAT)
        |-> (held_key_reg != akdr_pkg::NO_KEY &&
             held_key_reg <= akdr_pkg::KEY_W'(akdr_pkg::NUM_KEYS)))
        else $error("repeat phase without a valid key");

    // A sample processed while idle or confirming never fires an event.
    a_quiet_before_held: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (phase_reg == akdr_pkg::PH_IDLE || phase_reg == akdr_pkg::PH_CONFIRM))
        |=> (key_event_reg == akdr_pkg::NO_KEY))
        else $error("event fired before the key was held");

    // A waiting event must not block the input while the sample stage is free.
    a_take_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_stall && !s1_valid_reg) |-> !sample_stall)
        else $error("input stalled with a free sample stage");
`endif

endmodule : adc_ladder_key_debounce_repeat_unit

`default_nettype wire

// File: hw/rtl/akdr_ladder.sv
// Threshold ladder that turns one converter sample into a key code.
`timescale 1ns / 1ps
`default_nettype none

module akdr_ladder
(
    input  wire logic [akdr_pkg::ADC_BITS-1:0] sample,
    output logic      [akdr_pkg::KEY_W-1:0]    key
);

    logic [akdr_pkg::LADDER_BITS-1:0] level;

    // Bring the sample to the 12-bit scale of the threshold table.
    generate
        if (akdr_pkg::ADC_BITS >= akdr_pkg::LADDER_BITS) begin : g_narrow
            assign level = sample[akdr_pkg::ADC_BITS-1 -: akdr_pkg::LADDER_BITS];
        end
        else begin : g_widen
            assign level = {sample, {(akdr_pkg::LADDER_BITS - akdr_pkg::ADC_BITS){1'b0}}};
        end
    endgenerate

    // The lowest band that the level falls under wins.
    always_comb
    begin
        key = akdr_pkg::NO_KEY;
        for (int i = akdr_pkg::NUM_KEYS - 1; i >= 0; i--)
        begin
            if (level < akdr_pkg::LADDER_TOP[i])
            begin
                key = akdr_pkg::KEY_W'(i + 1);
            end
        end
    end

endmodule : akdr_ladder

`default_nettype wire
